// ===== hdl/lcsa_pkg.sv =====
// Shared types and constants of the leveled connection slot allocator.
package lcsa_pkg;

    localparam int SLOTS    = 16;
    localparam int LEVELS   = 8;
    localparam int SERVERS  = 16;
    localparam int GROUPS   = 16;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int LEVEL_W  = $clog2(LEVELS);
    localparam int SERVER_W = $clog2(SERVERS);
    localparam int GROUP_W  = $clog2(GROUPS);

    localparam int COUNT_W  = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_SWEEP   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  slot_index;
        logic [3:0]  server_id;
        logic [2:0]  level;
        logic [3:0]  server_group;
        logic        want_any;
        logic [15:0] ignore_servers;
        logic [15:0] ignore_groups;
        logic        used;
        logic [31:0] now_time;
        logic [15:0] connected_mask;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic [3:0] slot_out;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [SERVER_W-1:0] server;
        logic [LEVEL_W-1:0]  level;
        logic [GROUP_W-1:0]  group;
    } t_attr;

    localparam int ATTR_W = $bits(t_attr);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL,
        S_FINISH
    } t_state;

endpackage

// ===== hdl/leveled_connection_slot_allocator_core.sv =====
// Top level of the leveled connection slot allocator: slot table, level counts and control.
//
// A request enters on the input channel (i_in_valid / o_in_stall) and yields one
// result on the output channel (o_out_valid / i_out_stall), except a sweep, which
// yields one result per slot to close, or one without ok if none is found, the
// final one marked last. The hold time is written through the configuration
// channel (i_cfg_valid / o_cfg_ready), which is always ready and must only be
// used while no request is in flight. Slot attributes and free times live in two
// small RAMs with registered reads; valid and busy bits and the per-level free
// counts are flip-flops. An acquire or sweep scan reads one slot table entry per
// cycle, except while a sweep pauses as below. A new request is taken once the
// final result sits in the output register. When the receiver stalls, the result
// is held unchanged and a sweep pauses its scan until the previous slot to close
// has been taken. Synchronous reset clears all slots to not loaded, all counts to
// zero and the hold time to 5 seconds.
module leveled_connection_slot_allocator_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lcsa_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lcsa_pkg::t_res o_out_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import lcsa_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;
    logic [HOLD_W-1:0]  r_hold;
    logic [SLOTS-1:0]   r_slot_valid;
    logic [SLOTS-1:0]   r_slot_busy;
    logic [COUNT_W-1:0] r_cnt [LEVELS];
    logic [SLOT_W:0]    r_ptr;
    logic               r_ev;
    logic [SLOT_W-1:0]  r_ev_idx;
    logic               r_res_ok;
    logic [SLOT_W-1:0]  r_res_slot;
    logic               r_out_valid;
    t_res               r_out;

    logic              in_acc, out_free, out_load;
    t_res              out_data;
    logic              attr_we, time_we;
    logic [SLOT_W-1:0] wr_addr;
    t_attr             attr_wdata, attr_q;
    logic [TIME_W-1:0] time_wdata, time_q, diff;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              issue, hit, block, ev_load;
    logic              acq_match, sweep_match;
    logic              load_ok, rel_ok, acq_possible;
    logic              cnt_inc, cnt_dec;
    logic [LEVEL_W-1:0] cnt_lvl;
    logic              set_valid, clr_busy, set_busy;
    logic [SLOT_W-1:0] busy_idx;
    logic              res_load, res_ok_n;
    logic [SLOT_W-1:0] res_slot_n;

    lcsa_ram #(.WIDTH(ATTR_W), .DEPTH(SLOTS)) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (wr_addr),
        .i_wdata (attr_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (attr_q)
    );

    lcsa_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (wr_addr),
        .i_wdata (time_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (time_q)
    );

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;
    assign o_cfg_ready = 1'b1;

    assign load_ok = (int'(i_in_req.slot_index) < SLOTS) && (int'(i_in_req.level) < LEVELS)
                  && (int'(i_in_req.server_id) < SERVERS)
                  && (int'(i_in_req.server_group) < GROUPS);
    assign rel_ok  = (int'(i_in_req.slot_index) < SLOTS)
                  && r_slot_valid[SLOT_W'(i_in_req.slot_index)]
                  && r_slot_busy[SLOT_W'(i_in_req.slot_index)];
    assign acq_possible = (int'(i_in_req.level) < LEVELS)
                       && (r_cnt[LEVEL_W'(i_in_req.level)] != '0);

    assign issue = (r_ptr < (SLOT_W+1)'(SLOTS));

    // Candidate check for the entry whose table data arrived this cycle.
    always_comb begin
        acq_match = r_ev && r_slot_valid[r_ev_idx] && !r_slot_busy[r_ev_idx]
                 && (attr_q.level == LEVEL_W'(r_req.level));
        if (r_req.want_any) begin
            acq_match = acq_match && !r_req.ignore_servers[attr_q.server]
                     && !((attr_q.group != '0) && r_req.ignore_groups[attr_q.group]);
        end else begin
            acq_match = acq_match && ((attr_q.server == SERVER_W'(r_req.server_id))
                     || ((r_req.server_group != '0)
                         && (GROUP_W'(r_req.server_group) == attr_q.group)));
        end
    end

    // The idle time counts only if it is positive as a signed 32-bit difference.
    assign diff = r_req.now_time - time_q;
    assign sweep_match = r_ev && r_slot_valid[r_ev_idx] && !r_slot_busy[r_ev_idx]
                      && r_req.connected_mask[r_ev_idx] && !diff[TIME_W-1]
                      && (diff > TIME_W'(r_hold));

    assign hit = (r_req.cmd == CMD_ACQUIRE) ? acq_match : sweep_match;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_req.cmd)
                        CMD_LOAD:    n_state = S_FINISH;
                        CMD_ACQUIRE: n_state = acq_possible ? S_SCAN : S_FINISH;
                        CMD_RELEASE: n_state = rel_ok ? S_REL : S_FINISH;
                        CMD_SWEEP:   n_state = S_SCAN;
                        default:     n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN: begin
                if ((r_req.cmd == CMD_ACQUIRE) && hit) begin
                    n_state = S_FINISH;
                end else if (!r_ev && !issue) begin
                    n_state = S_FINISH;
                end
            end
            S_REL:    n_state = S_FINISH;
            S_FINISH: n_state = out_free ? S_IDLE : S_FINISH;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        out_load   = 1'b0;
        out_data   = '0;
        attr_we    = 1'b0;
        time_we    = 1'b0;
        wr_addr    = SLOT_W'(i_in_req.slot_index);
        attr_wdata = '{server: SERVER_W'(i_in_req.server_id),
                       level:  LEVEL_W'(i_in_req.level),
                       group:  GROUP_W'(i_in_req.server_group)};
        time_wdata = '0;
        rd_en      = 1'b0;
        rd_addr    = r_ptr[SLOT_W-1:0];
        block      = 1'b0;
        ev_load    = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        cnt_lvl    = LEVEL_W'(i_in_req.level);
        set_valid  = 1'b0;
        clr_busy   = 1'b0;
        set_busy   = 1'b0;
        busy_idx   = SLOT_W'(i_in_req.slot_index);
        res_load   = 1'b0;
        res_ok_n   = 1'b0;
        res_slot_n = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    res_load = 1'b1;
                    unique case (i_in_req.cmd)
                        CMD_LOAD: begin
                            if (load_ok) begin
                                attr_we    = 1'b1;
                                time_we    = 1'b1;
                                set_valid  = 1'b1;
                                clr_busy   = 1'b1;
                                cnt_inc    = 1'b1;
                                res_ok_n   = 1'b1;
                                res_slot_n = SLOT_W'(i_in_req.slot_index);
                            end
                        end
                        CMD_RELEASE: begin
                            if (rel_ok) begin
                                clr_busy   = 1'b1;
                                time_we    = i_in_req.used;
                                time_wdata = i_in_req.now_time;
                                rd_en      = 1'b1;
                                rd_addr    = SLOT_W'(i_in_req.slot_index);
                                res_ok_n   = 1'b1;
                                res_slot_n = SLOT_W'(i_in_req.slot_index);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_req.cmd == CMD_ACQUIRE) begin
                    if (hit) begin
                        set_busy   = 1'b1;
                        busy_idx   = r_ev_idx;
                        cnt_dec    = 1'b1;
                        cnt_lvl    = LEVEL_W'(r_req.level);
                        res_load   = 1'b1;
                        res_ok_n   = 1'b1;
                        res_slot_n = r_ev_idx;
                    end
                end else if (hit) begin
                    // The previous slot to close goes out only once a later one is
                    // found; the last one found is sent from the finish state.
                    if (r_res_ok) begin
                        if (out_free) begin
                            out_load = 1'b1;
                            out_data = '{ok: 1'b1, slot_out: 4'(r_res_slot), last: 1'b0};
                        end else begin
                            block = 1'b1;
                        end
                    end
                    if (!block) begin
                        res_load   = 1'b1;
                        res_ok_n   = 1'b1;
                        res_slot_n = r_ev_idx;
                    end
                end
                if (!block) begin
                    rd_en   = issue;
                    ev_load = 1'b1;
                end
            end
            S_REL: begin
                cnt_inc = 1'b1;
                cnt_lvl = attr_q.level;
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{ok: r_res_ok,
                                 slot_out: r_res_ok ? 4'(r_res_slot) : 4'd0,
                                 last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hold       <= HOLD_RESET;
            r_slot_valid <= '0;
            r_slot_busy  <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_cnt[l] <= '0;
            end
            r_ptr       <= '0;
            r_ev        <= 1'b0;
            r_res_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_hold <= i_cfg_data;
            end
            if (set_valid) begin
                r_slot_valid[wr_addr] <= 1'b1;
            end
            if (clr_busy) begin
                r_slot_busy[busy_idx] <= 1'b0;
            end
            if (set_busy) begin
                r_slot_busy[busy_idx] <= 1'b1;
            end
            if (cnt_inc && (r_cnt[cnt_lvl] != COUNT_MAX)) begin
                r_cnt[cnt_lvl] <= r_cnt[cnt_lvl] + 1'b1;
            end
            if (cnt_dec) begin
                r_cnt[cnt_lvl] <= r_cnt[cnt_lvl] - 1'b1;
            end
            if (in_acc) begin
                r_ptr <= '0;
                r_ev  <= 1'b0;
            end else if (ev_load) begin
                r_ev <= issue;
                if (issue) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (res_load) begin
                r_res_ok <= res_ok_n;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_req;
        end
        if (ev_load && issue) begin
            r_ev_idx <= r_ptr[SLOT_W-1:0];
        end
        if (res_load) begin
            r_res_slot <= res_slot_n;
        end
        if (out_load) begin
            r_out <= out_data;
        end
    end

    // A refused or failed request never names a slot.
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.ok) |-> (o_out_res.slot_out == '0))
        else $error("result without ok carries a nonzero slot");

    // Only sweep results to close a slot may precede the final one.
    a_nonlast_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.last) |-> o_out_res.ok)
        else $error("non-final result without ok");

    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot_busy & ~r_slot_valid) == '0)
        else $error("busy slot that was never loaded");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second request taken while the first is in flight");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= (SLOT_W+1)'(SLOTS)))
        else $error("scan pointer beyond the slot table");

endmodule

// ===== hdl/lcsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lcsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
